// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file of the vector rotation block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define VR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define VR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define VR_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define VR_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- hw/rtl/vr2d_pkg.sv -----
// Package with types, constants and tables of the vector rotation block.
`default_nettype none
package vr2d_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int ITERATIONS_DEF = 16;
    localparam int ATAN_LEN       = 24;
    localparam int XY_W           = 32;
    localparam int ANGLE_W        = 16;
    localparam int ZW             = 32;
    localparam int PROD_W         = 65;
    localparam int XY_MAX         = 2147483647;
    localparam int XY_MIN         = -2147483647 - 1;

    localparam logic [31:0]        GAIN_Q32     = 32'd2608131496;
    localparam logic [ANGLE_W-1:0] QUARTER_OFS  = 16'h2000;
    localparam logic signed [14:0] RESIDUAL_OFS = 15'sd8192;

    typedef enum logic [1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } t_quad;

    function automatic int guard_bits(input int dw);
        int g;
        if (dw < 16) begin
            g = 0;
        end else begin
            g = (dw - 16) >> 1;
        end
        if (g > 16) begin
            g = 16;
        end
        return g;
    endfunction

    function automatic int rot_count(input int n);
        int c;
        c = n;
        if (c > ATAN_LEN) begin
            c = ATAN_LEN;
        end
        if (c < 0) begin
            c = 0;
        end
        return c;
    endfunction

    function automatic logic [ZW-1:0] atan_entry(input int i);
        logic [ZW-1:0] v;
        case (i)
            0:       v = 32'h20000000;
            1:       v = 32'h12E4051E;
            2:       v = 32'h09FB385B;
            3:       v = 32'h051111D4;
            4:       v = 32'h028B0D43;
            5:       v = 32'h0145D7E1;
            6:       v = 32'h00A2F61E;
            7:       v = 32'h00517C55;
            8:       v = 32'h0028BE53;
            9:       v = 32'h00145F2F;
            10:      v = 32'h000A2F98;
            11:      v = 32'h000517CC;
            12:      v = 32'h00028BE6;
            13:      v = 32'h000145F3;
            14:      v = 32'h0000A2F9;
            15:      v = 32'h0000517C;
            16:      v = 32'h000028BE;
            17:      v = 32'h0000145F;
            18:      v = 32'h00000A2F;
            19:      v = 32'h00000517;
            20:      v = 32'h0000028B;
            21:      v = 32'h00000145;
            22:      v = 32'h000000A2;
            23:      v = 32'h00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/vector_rotate_2d_top.sv -----
// Top level of the pipelined CORDIC 2D vector rotator.
// Rotates a signed Q16.16 vector counter-clockwise by a 16-bit binary angle
// (65536 is a full turn) and returns saturated Q16.16 components. One item
// enters per clock while o_stall is low. The pipeline holds the gain multiply,
// rounding and quarter-turn step, a stage per micro-rotation (ITERATIONS, at
// most 24), then rounding and saturation. A stall on the output freezes only
// as much of the pipeline as is full; empty stages keep taking items. DATA_WIDTH
// sets the internal guard bits ((DATA_WIDTH - 16) / 2, limited to 0..16).
`default_nettype none
`include "assert_macros.svh"
module vector_rotate_2d_top #(
    parameter int DATA_WIDTH = vr2d_pkg::DATA_WIDTH_DEF,
    parameter int ITERATIONS = vr2d_pkg::ITERATIONS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic signed [vr2d_pkg::XY_W-1:0]  i_x_in,
    input  wire logic signed [vr2d_pkg::XY_W-1:0]  i_y_in,
    input  wire logic [vr2d_pkg::ANGLE_W-1:0]      i_angle,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic signed [vr2d_pkg::XY_W-1:0]       o_x_out,
    output logic signed [vr2d_pkg::XY_W-1:0]       o_y_out
);
    import vr2d_pkg::*;

    localparam int GUARD = guard_bits(DATA_WIDTH);
    localparam int IW    = XY_W + 3 + GUARD;
    localparam int N_ROT = rot_count(ITERATIONS);

    logic [N_ROT:0]       w_valid;
    logic [N_ROT:0]       w_ready;
    logic signed [IW-1:0] w_x [0:N_ROT];
    logic signed [IW-1:0] w_y [0:N_ROT];
    logic signed [ZW-1:0] w_z [0:N_ROT];
    logic                 w_in_ready;

    assign o_stall = !w_in_ready;

    vr2d_prescale #(
        .GUARD (GUARD),
        .IW    (IW)
    ) u_prescale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (w_in_ready),
        .i_x     (i_x_in),
        .i_y     (i_y_in),
        .i_angle (i_angle),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_x     (w_x[0]),
        .o_y     (w_y[0]),
        .o_z     (w_z[0])
    );

    for (genvar k = 1; k <= N_ROT; k++) begin : g_rot
        vr2d_micro_rot #(
            .IW   (IW),
            .STEP (k - 1)
        ) u_rot (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k-1]),
            .o_ready (w_ready[k-1]),
            .i_x     (w_x[k-1]),
            .i_y     (w_y[k-1]),
            .i_z     (w_z[k-1]),
            .o_valid (w_valid[k]),
            .i_ready (w_ready[k]),
            .o_x     (w_x[k]),
            .o_y     (w_y[k]),
            .o_z     (w_z[k])
        );
    end

    vr2d_finish #(
        .GUARD (GUARD),
        .IW    (IW)
    ) u_finish (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[N_ROT]),
        .o_ready (w_ready[N_ROT]),
        .i_x     (w_x[N_ROT]),
        .i_y     (w_y[N_ROT]),
        .o_valid (o_valid),
        .i_ready (!i_stall),
        .o_x     (o_x_out),
        .o_y     (o_y_out)
    );

    `VR_ASSERT_IMP(a_stall_only_full, i_clk, i_rst_n, o_stall, (&w_valid) && o_valid)
    `VR_ASSERT_IMP(a_open_sink_no_stall, i_clk, i_rst_n, !i_stall, !o_stall)
    `VR_ASSERT_NEXT(a_drain_empty, i_clk, i_rst_n, o_valid && !i_stall && !w_valid[N_ROT], !o_valid)

endmodule
`default_nettype wire

// ----- hw/rtl/vr2d_prescale.sv -----
// Gain prescale, rounding and quarter-turn pre-rotation of the vector; splits off the residual angle.
`default_nettype none
module vr2d_prescale #(
    parameter int GUARD = vr2d_pkg::guard_bits(vr2d_pkg::DATA_WIDTH_DEF),
    parameter int IW    = vr2d_pkg::XY_W + 3 + GUARD
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic signed [vr2d_pkg::XY_W-1:0]  i_x,
    input  wire logic signed [vr2d_pkg::XY_W-1:0]  i_y,
    input  wire logic [vr2d_pkg::ANGLE_W-1:0]      i_angle,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic signed [IW-1:0]                   o_x,
    output logic signed [IW-1:0]                   o_y,
    output logic signed [vr2d_pkg::ZW-1:0]         o_z
);
    import vr2d_pkg::*;

    localparam int SH = XY_W - GUARD;
    localparam logic signed [PROD_W-1:0] P_RND = PROD_W'(65'sd1 <<< (SH - 1));

    logic                     r_va, r_vb, r_vc;
    logic                     w_rdy_a, w_rdy_b, w_rdy_c;
    logic signed [PROD_W-1:0] r_px, r_py;
    logic signed [PROD_W-1:0] n_px, n_py;
    t_quad                    r_qa, r_qb;
    logic signed [ZW-1:0]     r_za, r_zb, r_zc;
    logic signed [ZW-1:0]     n_z;
    logic signed [IW-1:0]     r_xb, r_yb, r_xc, r_yc;
    logic signed [IW-1:0]     n_xb, n_yb, n_xc, n_yc;
    logic signed [PROD_W-1:0] w_sx, w_sy, w_hx, w_hy;
    logic signed [32:0]       w_gain;
    logic [ANGLE_W-1:0]       w_a;
    logic signed [14:0]       w_res;

    assign w_rdy_c = !r_vc || i_ready;
    assign w_rdy_b = !r_vb || w_rdy_c;
    assign w_rdy_a = !r_va || w_rdy_b;
    assign o_ready = w_rdy_a;
    assign o_valid = r_vc;

    assign w_gain = $signed({1'b0, GAIN_Q32});
    assign n_px   = i_x * w_gain;
    assign n_py   = i_y * w_gain;
    assign w_a    = i_angle + QUARTER_OFS;
    assign w_res  = $signed({1'b0, w_a[13:0]}) - RESIDUAL_OFS;
    assign n_z    = {w_res[14], w_res, 16'h0000};

    assign w_sx = r_px + P_RND;
    assign w_sy = r_py + P_RND;
    assign w_hx = w_sx >>> SH;
    assign w_hy = w_sy >>> SH;
    assign n_xb = w_hx[IW-1:0];
    assign n_yb = w_hy[IW-1:0];

    always_comb begin
        case (r_qb)
            QUAD_90: begin
                n_xc = -r_yb;
                n_yc = r_xb;
            end
            QUAD_180: begin
                n_xc = -r_xb;
                n_yc = -r_yb;
            end
            QUAD_270: begin
                n_xc = r_yb;
                n_yc = -r_xb;
            end
            default: begin
                n_xc = r_xb;
                n_yc = r_yb;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (w_rdy_a) begin
                r_va <= i_valid;
            end
            if (w_rdy_b) begin
                r_vb <= r_va;
            end
            if (w_rdy_c) begin
                r_vc <= r_vb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_a && i_valid) begin
            r_px <= n_px;
            r_py <= n_py;
            r_qa <= t_quad'(w_a[15:14]);
            r_za <= n_z;
        end
        if (w_rdy_b && r_va) begin
            r_xb <= n_xb;
            r_yb <= n_yb;
            r_qb <= r_qa;
            r_zb <= r_za;
        end
        if (w_rdy_c && r_vb) begin
            r_xc <= n_xc;
            r_yc <= n_yc;
            r_zc <= r_zb;
        end
    end

    assign o_x = r_xc;
    assign o_y = r_yc;
    assign o_z = r_zc;

endmodule
`default_nettype wire

// ----- hw/rtl/vr2d_micro_rot.sv -----
// One CORDIC micro-rotation stage with its pipeline register.
`default_nettype none
module vr2d_micro_rot #(
    parameter int IW   = vr2d_pkg::XY_W + 3 + vr2d_pkg::guard_bits(vr2d_pkg::DATA_WIDTH_DEF),
    parameter int STEP = 0
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic signed [IW-1:0]              i_x,
    input  wire logic signed [IW-1:0]              i_y,
    input  wire logic signed [vr2d_pkg::ZW-1:0]    i_z,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic signed [IW-1:0]                   o_x,
    output logic signed [IW-1:0]                   o_y,
    output logic signed [vr2d_pkg::ZW-1:0]         o_z
);
    import vr2d_pkg::*;

    localparam logic signed [ZW-1:0] P_ATAN = $signed(atan_entry(STEP));

    logic                 r_valid;
    logic                 w_rdy;
    logic signed [IW-1:0] r_x, r_y, n_x, n_y;
    logic signed [ZW-1:0] r_z, n_z;
    logic signed [IW-1:0] w_dx, w_dy;

    assign w_rdy   = !r_valid || i_ready;
    assign o_ready = w_rdy;
    assign o_valid = r_valid;

    assign w_dx = i_y >>> STEP;
    assign w_dy = i_x >>> STEP;

    always_comb begin
        if (!i_z[ZW-1]) begin
            n_x = i_x - w_dx;
            n_y = i_y + w_dy;
            n_z = i_z - P_ATAN;
        end else begin
            n_x = i_x + w_dx;
            n_y = i_y - w_dy;
            n_z = i_z + P_ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_rdy) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy && i_valid) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule
`default_nettype wire

// ----- hw/rtl/vr2d_finish.sv -----
// Output stage: drop guard bits with rounding, saturate, hold the result.
`default_nettype none
module vr2d_finish #(
    parameter int GUARD = vr2d_pkg::guard_bits(vr2d_pkg::DATA_WIDTH_DEF),
    parameter int IW    = vr2d_pkg::XY_W + 3 + GUARD
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic signed [IW-1:0]              i_x,
    input  wire logic signed [IW-1:0]              i_y,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic signed [vr2d_pkg::XY_W-1:0]       o_x,
    output logic signed [vr2d_pkg::XY_W-1:0]       o_y
);
    import vr2d_pkg::*;

    localparam int RND_I = (GUARD > 0) ? (1 << (GUARD - 1)) : 0;
    localparam logic signed [IW:0] P_RND = (IW + 1)'(RND_I);
    localparam logic signed [IW:0] P_MAX = (IW + 1)'(XY_MAX);
    localparam logic signed [IW:0] P_MIN = (IW + 1)'(XY_MIN);
    localparam logic [XY_W-1:0]    SAT_HI = {1'b0, {(XY_W - 1){1'b1}}};
    localparam logic [XY_W-1:0]    SAT_LO = {1'b1, {(XY_W - 1){1'b0}}};

    logic                   r_valid;
    logic                   w_rdy;
    logic signed [IW:0]     w_sx, w_sy, w_rx, w_ry;
    logic signed [XY_W-1:0] r_x, r_y, n_x, n_y;

    assign w_rdy   = !r_valid || i_ready;
    assign o_ready = w_rdy;
    assign o_valid = r_valid;

    assign w_sx = (IW + 1)'(i_x) + P_RND;
    assign w_sy = (IW + 1)'(i_y) + P_RND;
    assign w_rx = w_sx >>> GUARD;
    assign w_ry = w_sy >>> GUARD;

    always_comb begin
        if (w_rx > P_MAX) begin
            n_x = SAT_HI;
        end else if (w_rx < P_MIN) begin
            n_x = SAT_LO;
        end else begin
            n_x = w_rx[XY_W-1:0];
        end
        if (w_ry > P_MAX) begin
            n_y = SAT_HI;
        end else if (w_ry < P_MIN) begin
            n_y = SAT_LO;
        end else begin
            n_y = w_ry[XY_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_rdy) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy && i_valid) begin
            r_x <= n_x;
            r_y <= n_y;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;

endmodule
`default_nettype wire

// ----- sim/vector_rotate_2d_top_tb.sv -----
// Testbench for vector_rotate_2d_top: directed and random items checked against a CORDIC predictor.
`timescale 1ns / 1ps
`default_nettype none
module vector_rotate_2d_top_tb;
    import vr2d_pkg::*;

    localparam int DW       = 32;
    localparam int ITER     = 16;
    localparam int GUARD    = ((DW - 16) / 2 > 16) ? 16 : ((DW < 16) ? 0 : (DW - 16) / 2);
    localparam int NUM_ROT  = (ITER > 24) ? 24 : ((ITER < 0) ? 0 : ITER);
    localparam int LATENCY  = ITER + 4;
    localparam int LIMIT    = 200000;
    localparam int RAND_PER_PHASE = 225;
    localparam int MAX_PRINTS     = 40;

    localparam longint GAIN_K = 64'sd2608131496;
    localparam logic [15:0] EIGHTH_TURN = 16'h2000;
    localparam logic signed [31:0] POS_FULL = 32'sh7FFFFFFF;
    localparam logic signed [31:0] NEG_FULL = 32'sh80000000;
    localparam logic signed [31:0] Q_ONE    = 32'sh00010000;

    // arctangent steps in 2^-32 turn, entry 0 in the low word
    localparam logic [24*32-1:0] ATAN_STEPS = {
        32'h00000051, 32'h000000A2, 32'h00000145, 32'h0000028B,
        32'h00000517, 32'h00000A2F, 32'h0000145F, 32'h000028BE,
        32'h0000517C, 32'h0000A2F9, 32'h000145F3, 32'h00028BE6,
        32'h000517CC, 32'h000A2F98, 32'h00145F2F, 32'h0028BE53,
        32'h00517C55, 32'h00A2F61E, 32'h0145D7E1, 32'h028B0D43,
        32'h051111D4, 32'h09FB385B, 32'h12E4051E, 32'h20000000
    };

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } t_rotated_vec;

    class t_rotation_scoreboard;
        t_rotated_vec expected_q[$];
        int mismatches;
        int items_noted;
        int results_checked;

        function new();
            mismatches      = 0;
            items_noted     = 0;
            results_checked = 0;
        endfunction

        function longint gain_scale(logic signed [31:0] v);
            longint p;
            p = longint'(v) * GAIN_K;
            p = p + (64'sd1 <<< (31 - GUARD));
            return p >>> (32 - GUARD);
        endfunction

        function logic signed [31:0] round_saturate(longint v);
            longint r;
            r = v;
            if (GUARD > 0) begin
                r = (v + (64'sd1 <<< (GUARD - 1))) >>> GUARD;
            end
            if (r > longint'(POS_FULL)) begin
                r = longint'(POS_FULL);
            end
            if (r < longint'(NEG_FULL)) begin
                r = longint'(NEG_FULL);
            end
            return r[31:0];
        endfunction

        function t_rotated_vec rotate_vector(logic signed [31:0] xv, logic signed [31:0] yv,
                                             logic [15:0] ang);
            longint px, py, tmp, dx, dy, zacc, step;
            logic [15:0] a_ofs;
            t_quad quad;
            t_rotated_vec r;
            px = gain_scale(xv);
            py = gain_scale(yv);
            a_ofs = ang + EIGHTH_TURN;
            quad = t_quad'(a_ofs[15:14]);
            zacc = (longint'(a_ofs[13:0]) - 64'sd8192) * 64'sd65536;
            case (quad)
                QUAD_90: begin
                    tmp = px;
                    px  = -py;
                    py  = tmp;
                end
                QUAD_180: begin
                    px = -px;
                    py = -py;
                end
                QUAD_270: begin
                    tmp = px;
                    px  = py;
                    py  = -tmp;
                end
                default: begin
                end
            endcase
            for (int i = 0; i < NUM_ROT; i++) begin
                dx = py >>> i;
                dy = px >>> i;
                step = longint'(ATAN_STEPS[i*32 +: 32]);
                if (zacc >= 0) begin
                    px   = px - dx;
                    py   = py + dy;
                    zacc = zacc - step;
                end else begin
                    px   = px + dx;
                    py   = py - dy;
                    zacc = zacc + step;
                end
            end
            r.x = round_saturate(px);
            r.y = round_saturate(py);
            return r;
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= MAX_PRINTS) begin
                $display("tb: mismatch: %s", msg);
            end
        endtask

        function void note_item(logic signed [31:0] xv, logic signed [31:0] yv, logic [15:0] ang);
            expected_q.push_back(rotate_vector(xv, yv, ang));
            items_noted++;
        endfunction

        task check_result(logic signed [31:0] xv, logic signed [31:0] yv);
            t_rotated_vec e;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result x=%0d y=%0d", xv, yv));
            end else begin
                e = expected_q.pop_front();
                results_checked++;
                if (xv !== e.x) begin
                    report_mismatch($sformatf("result %0d x_out got %0d exp %0d",
                                              results_checked, xv, e.x));
                end
                if (yv !== e.y) begin
                    report_mismatch($sformatf("result %0d y_out got %0d exp %0d",
                                              results_checked, yv, e.y));
                end
            end
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic signed [31:0] i_x_in = '0;
    logic signed [31:0] i_y_in = '0;
    logic [15:0] i_angle = '0;
    logic o_stall;
    logic o_valid;
    logic signed [31:0] o_x_out;
    logic signed [31:0] o_y_out;

    int idle_pct  = 0;
    int stall_pct = 0;
    int directed_count = 0;
    int cycle_count = 0;
    t_rotation_scoreboard rot_sb = new();

    vector_rotate_2d_top #(
        .DATA_WIDTH(DW),
        .ITERATIONS(ITER)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_x_in (i_x_in),
        .i_y_in (i_y_in),
        .i_angle(i_angle),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_x_out(o_x_out),
        .o_y_out(o_y_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: timeout after %0d cycles", cycle_count);
        $display("tb: failure");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            rot_sb.check_result(o_x_out, o_y_out);
        end
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    task send_item(logic signed [31:0] xv, logic signed [31:0] yv, logic [15:0] ang);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_x_in  <= xv;
        i_y_in  <= yv;
        i_angle <= ang;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        rot_sb.note_item(xv, yv, ang);
    endtask

    function automatic logic signed [31:0] extreme_value();
        case ($urandom_range(0, 5))
            0: return POS_FULL;
            1: return NEG_FULL;
            2: return 32'sd0;
            3: return -32'sd1;
            4: return Q_ONE;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic signed [31:0] xv, yv;
        logic [15:0] ang;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // field extremes, quadrant boundaries, saturation
        send_item(32'sd0, 32'sd0, 16'h0000);
        send_item(Q_ONE, 32'sd0, 16'h0000);
        send_item(Q_ONE, 32'sd0, 16'h4000);
        send_item(Q_ONE, 32'sd0, 16'h8000);
        send_item(Q_ONE, 32'sd0, 16'hC000);
        send_item(Q_ONE, Q_ONE, 16'h1FFF);
        send_item(Q_ONE, Q_ONE, 16'h2000);
        send_item(Q_ONE, -Q_ONE, 16'h5FFF);
        send_item(Q_ONE, -Q_ONE, 16'h6000);
        send_item(-Q_ONE, Q_ONE, 16'hA000);
        send_item(-Q_ONE, Q_ONE, 16'hDFFF);
        send_item(-Q_ONE, -Q_ONE, 16'hE000);
        send_item(Q_ONE, Q_ONE, 16'hFFFF);
        send_item(POS_FULL, POS_FULL, 16'h2000);
        send_item(NEG_FULL, NEG_FULL, 16'h2000);
        send_item(NEG_FULL, 32'sd0, 16'h8000);
        send_item(32'sd0, NEG_FULL, 16'h4000);
        send_item(POS_FULL, NEG_FULL, 16'hE000);
        send_item(-32'sd1, 32'sd1, 16'h1234);
        send_item(32'sh5A5A5A5A, 32'shA5A5A5A5, 16'hFFFF);
        directed_count = rot_sb.items_noted;

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 53; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 53; end
                default: begin idle_pct = 18; stall_pct = 18; end
            endcase
            repeat (RAND_PER_PHASE) begin
                ang = 16'($urandom);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin
                        xv = $urandom;
                        yv = $urandom;
                    end
                    4, 5, 6: begin
                        xv = int'($urandom_range(0, 32'h3FFFFF)) - 32'sh200000;
                        yv = int'($urandom_range(0, 32'h3FFFFF)) - 32'sh200000;
                    end
                    7: begin
                        xv = extreme_value();
                        yv = extreme_value();
                    end
                    default: begin
                        xv = int'($urandom_range(0, 32'h3FFFFFF)) - 32'sh2000000;
                        yv = int'($urandom_range(0, 32'h3FFFFFF)) - 32'sh2000000;
                        ang = EIGHTH_TURN + 16'($urandom_range(0, 3) << 14)
                              + 16'($urandom_range(0, 8)) - 16'd4;
                    end
                endcase
                send_item(xv, yv, ang);
            end
        end
        i_valid <= 1'b0;
        stall_pct = 0;

        while (rot_sb.pending() > 0) begin
            @(posedge i_clk);
        end
        repeat (2 * LATENCY) @(posedge i_clk);

        $display("tb: %0d items sent (%0d directed, rest random over four idle/stall phases)",
                 rot_sb.items_noted, directed_count);
        $display("tb: %0d results checked, %0d mismatches, %0d still outstanding",
                 rot_sb.results_checked, rot_sb.mismatches, rot_sb.pending());
        if (rot_sb.mismatches == 0 && rot_sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ----- vector_rotate_2d_top.f -----
+incdir+hw/rtl
hw/rtl/vr2d_pkg.sv
hw/rtl/vr2d_prescale.sv
hw/rtl/vr2d_micro_rot.sv
hw/rtl/vr2d_finish.sv
hw/rtl/vector_rotate_2d_top.sv
sim/vector_rotate_2d_top_tb.sv
